// File: rtl/utf8d_pkg.sv
// shared types and constants for the validating utf-8 decoder
package utf8d_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_TERM = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // configuration register indexes
    localparam logic [1:0] CFG_OUTPUT_UTF16      = 2'd0;
    localparam logic [1:0] CFG_STOP_ON_NUL       = 2'd1;
    localparam logic [1:0] CFG_APPEND_TERMINATOR = 2'd2;

    // field widths
    localparam int CODE_W = 21;
    localparam int MAX_RESULTS = 3;

    // lead and second byte limits
    localparam logic [7:0] LEAD_MIN      = 8'hC2;
    localparam logic [7:0] LEAD_MAX      = 8'hF4;
    localparam logic [7:0] LEAD_3BYTE    = 8'hE0;
    localparam logic [7:0] LEAD_4BYTE    = 8'hF0;
    localparam logic [7:0] LEAD_SURR     = 8'hED;
    localparam logic [7:0] TRAIL_MIN     = 8'h80;
    localparam logic [7:0] TRAIL_MAX     = 8'hBF;
    localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
    localparam logic [7:0] ED_SECOND_MAX = 8'h9F;
    localparam logic [7:0] F0_SECOND_MIN = 8'h90;
    localparam logic [7:0] F4_SECOND_MAX = 8'h8F;

    // utf-16 surrogate bases, upper six bits of the 16-bit unit
    localparam logic [5:0] HI_SURR_TOP = 6'b110110;  // D800
    localparam logic [5:0] LO_SURR_TOP = 6'b110111;  // DC00
    localparam logic [CODE_W-1:0] BMP_MAX   = 21'h00FFFF;
    localparam logic [CODE_W-1:0] PLANE1    = 21'h010000;

    typedef struct packed {
        logic output_utf16;
        logic stop_on_nul;
        logic append_terminator;
    } cfg_t;

    // up to three results produced by one byte
    typedef struct packed {
        logic [MAX_RESULTS-1:0][CODE_W-1:0] unit;
        logic [MAX_RESULTS-1:0][1:0]        kind;
        logic [1:0]                         count;
    } dec_out_t;

endpackage

// File: rtl/utf8d_decode.sv
// sequence state and combinational byte decode for the utf-8 decoder
module utf8d_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              end_of_text,
    input  utf8d_pkg::cfg_t   cfg,
    output utf8d_pkg::dec_out_t res
);
    import utf8d_pkg::*;

    logic [1:0]        missing_reg,  missing_next;
    logic [7:0]        lead_reg,     lead_next;
    logic              second_reg,   second_next;
    logic [CODE_W-1:0] partial_reg,  partial_next;
    logic              discard_reg,  discard_next;

    logic              have_char;
    logic              bad;
    logic              stop;
    logic              term;
    logic              pair;
    logic [CODE_W-1:0] cp;
    logic [CODE_W-1:0] cp_off;
    logic [7:0]        lo;
    logic [7:0]        hi;
    logic [1:0]        missing_dec;

    // sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            missing_reg <= '0;
            lead_reg    <= '0;
            second_reg  <= 1'b0;
            partial_reg <= '0;
            discard_reg <= 1'b0;
        end else if (accept) begin
            missing_reg <= missing_next;
            lead_reg    <= lead_next;
            second_reg  <= second_next;
            partial_reg <= partial_next;
            discard_reg <= discard_next;
        end
    end

    // byte classification and state update
    always_comb begin
        missing_next = missing_reg;
        lead_next    = lead_reg;
        second_next  = second_reg;
        partial_next = partial_reg;
        discard_next = discard_reg;
        have_char    = 1'b0;
        bad          = 1'b0;
        stop         = 1'b0;
        term         = 1'b0;
        cp           = '0;
        lo           = TRAIL_MIN;
        hi           = TRAIL_MAX;
        missing_dec  = missing_reg - 2'd1;

        if (discard_reg) begin
            if (end_of_text) begin
                discard_next = 1'b0;
            end
        end else begin
            if (missing_reg == 2'd0) begin
                if (cfg.stop_on_nul && data_byte == 8'h00) begin
                    stop = 1'b1;
                    term = cfg.append_terminator;
                end else if (!data_byte[7]) begin
                    have_char = 1'b1;
                    cp        = {13'b0, data_byte};
                end else if (data_byte < LEAD_MIN || data_byte > LEAD_MAX) begin
                    bad = 1'b1;
                end else begin
                    lead_next   = data_byte;
                    second_next = 1'b0;
                    if (data_byte < LEAD_3BYTE) begin
                        missing_next = 2'd1;
                        partial_next = {16'b0, data_byte[4:0]};
                    end else if (data_byte < LEAD_4BYTE) begin
                        missing_next = 2'd2;
                        partial_next = {17'b0, data_byte[3:0]};
                    end else begin
                        missing_next = 2'd3;
                        partial_next = {18'b0, data_byte[2:0]};
                    end
                end
            end else begin
                // tighter second byte limits exclude overlong, surrogate and out-of-range forms
                if (!second_reg) begin
                    if (lead_reg == LEAD_3BYTE) begin
                        lo = E0_SECOND_MIN;
                    end else if (lead_reg == LEAD_SURR) begin
                        hi = ED_SECOND_MAX;
                    end else if (lead_reg == LEAD_4BYTE) begin
                        lo = F0_SECOND_MIN;
                    end else if (lead_reg == LEAD_MAX) begin
                        hi = F4_SECOND_MAX;
                    end
                end
                if (data_byte < lo || data_byte > hi) begin
                    bad = 1'b1;
                end else begin
                    partial_next = {partial_reg[CODE_W-7:0], data_byte[5:0]};
                    second_next  = 1'b1;
                    missing_next = missing_dec;
                    if (missing_dec == 2'd0) begin
                        have_char    = 1'b1;
                        cp           = {partial_reg[CODE_W-7:0], data_byte[5:0]};
                        lead_next    = '0;
                        second_next  = 1'b0;
                        partial_next = '0;
                    end
                end
            end

            if (bad) begin
                missing_next = '0;
                lead_next    = '0;
                second_next  = 1'b0;
                partial_next = '0;
                discard_next = !end_of_text;
            end else if (stop) begin
                discard_next = !end_of_text;
            end else if (end_of_text && missing_next == 2'd0 && cfg.append_terminator) begin
                term = 1'b1;
            end
        end
    end

    // result assembly: surrogate split and terminator placement
    always_comb begin
        cp_off    = cp - PLANE1;
        pair      = have_char && cfg.output_utf16 && (cp > BMP_MAX);
        res.unit  = '0;
        res.kind  = {KIND_TERM, KIND_TERM, KIND_TERM};
        res.count = 2'd0;
        if (bad) begin
            res.kind[0] = KIND_ERR;
            res.count   = 2'd1;
        end else if (pair) begin
            res.unit[0] = {5'b0, HI_SURR_TOP, cp_off[19:10]};
            res.kind[0] = KIND_CHAR;
            res.unit[1] = {5'b0, LO_SURR_TOP, cp_off[9:0]};
            res.kind[1] = KIND_CHAR;
            res.count   = term ? 2'd3 : 2'd2;
        end else if (have_char) begin
            res.unit[0] = cp;
            res.kind[0] = KIND_CHAR;
            res.count   = term ? 2'd2 : 2'd1;
        end else begin
            res.count   = term ? 2'd1 : 2'd0;
        end
    end

endmodule

// File: rtl/utf8_validating_decoder_unit.sv
// top level of the validating utf-8 decoder with utf-32 / utf-16 output
//
// Takes one UTF-8 byte per transaction on the s_ channel and emits decoded units on the
// m_ channel: code points, or UTF-16 units with a surrogate pair above U+FFFF, optional zero
// terminators at text end, and an error result for any illegal byte, after which the rest of
// the text is dropped. A byte is decoded in the cycle it is accepted and its results (up to
// three) are held in a three-entry result register, shifted out one per cycle while m_ready
// is high. A byte with no result frees the input at once, one with a single result as that
// result is delivered, so plain text runs at one byte per cycle while m_ready is high; a byte
// with several results holds the input until its last result is delivered. Configuration
// writes are expected while no transaction is in flight; cfg_ready is always high.
module utf8_validating_decoder_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic                          cfg_data,
    // byte input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_end_of_text,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [utf8d_pkg::CODE_W-1:0]  m_code_unit,
    output logic [1:0]                    m_kind,
    output logic                          m_last
);
    import utf8d_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    dec_out_t res;

    logic [MAX_RESULTS-1:0][CODE_W-1:0] unit_reg, unit_next;
    logic [MAX_RESULTS-1:0][1:0]        kind_reg, kind_next;
    logic [1:0]                         cnt_reg,  cnt_next;

    logic s_accept;
    logic m_accept;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;
    assign m_accept  = m_valid && m_ready;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_OUTPUT_UTF16:      cfg_next.output_utf16      = cfg_data;
                CFG_STOP_ON_NUL:       cfg_next.stop_on_nul       = cfg_data;
                CFG_APPEND_TERMINATOR: cfg_next.append_terminator = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{output_utf16: 1'b0, stop_on_nul: 1'b0, append_terminator: 1'b1};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // decode core
    utf8d_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .data_byte   (s_data_byte),
        .end_of_text (s_end_of_text),
        .cfg         (cfg_reg),
        .res         (res)
    );

    // input is taken when the result register is empty or hands over its final entry
    assign s_ready = (cnt_reg == 2'd0) || (m_ready && cnt_reg == 2'd1);

    // result register: load on accept, shift down on each delivered transaction
    always_comb begin
        unit_next = unit_reg;
        kind_next = kind_reg;
        cnt_next  = cnt_reg;
        if (s_accept) begin
            unit_next = res.unit;
            kind_next = res.kind;
            cnt_next  = res.count;
        end else if (m_accept) begin
            unit_next[0] = unit_reg[1];
            unit_next[1] = unit_reg[2];
            kind_next[0] = kind_reg[1];
            kind_next[1] = kind_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        unit_reg <= unit_next;
        kind_reg <= kind_next;
    end

    assign m_valid     = (cnt_reg != 2'd0);
    assign m_code_unit = unit_reg[0];
    assign m_kind      = kind_reg[0];
    assign m_last      = (cnt_reg == 2'd1);

    // a byte that produces results shows them in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && res.count != 2'd0 |=> m_valid)
        else $error("decoded results not presented");

    // an error result is always the only result of its byte
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ERR |-> m_last)
        else $error("error result not last");

    // a terminator always closes its byte's results
    a_term_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_TERM |-> m_last)
        else $error("terminator not last");

    // a high surrogate is always followed by its low surrogate
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept && m_kind == KIND_CHAR && m_code_unit[CODE_W-1:10] == {5'b0, HI_SURR_TOP}
        |=> m_valid && m_kind == KIND_CHAR
            && m_code_unit[CODE_W-1:10] == {5'b0, LO_SURR_TOP})
        else $error("high surrogate without low surrogate");

endmodule
